// ===== sv/pulse_sweep_sound_generator_defines.svh =====
`ifndef PULSE_SWEEP_SOUND_GENERATOR_DEFINES_SVH
`define PULSE_SWEEP_SOUND_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked from reset release onwards.
`define PSG_ASSERT_NOW(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("psg: assertion failed");

// Next-cycle implication, checked from reset release onwards.
`define PSG_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("psg: assertion failed");

`endif

// ===== sv/psg_pkg.sv =====
package psg_pkg;

  localparam int unsigned RegW   = 8;
  localparam int unsigned WordW  = 16;
  localparam int unsigned IndexW = 3;

  typedef logic [RegW-1:0]  byte_t;
  typedef logic [WordW-1:0] word_t;

  typedef enum logic [IndexW-1:0] {
    REG_PITCH_HIGH     = 3'd0,
    REG_VIBRATO_STEP   = 3'd1,
    REG_VOLUME_START   = 3'd2,
    REG_SPLIT_POINT    = 3'd3,
    REG_DECAY_EXPONENT = 3'd4,
    REG_WIDTH_RATE     = 3'd5,
    REG_LINEAR_DECAY   = 3'd6
  } cfg_reg_e;

  localparam word_t PhaseInit     = 16'h0101;
  localparam word_t WidthInit     = 16'h0707;
  localparam byte_t EndLevel      = 8'h80;
  localparam byte_t ExpShiftLimit = 8'd9;
  localparam byte_t ExpHalfMin    = 8'h80;
  localparam byte_t LinearFloor   = 8'd1;

  localparam byte_t PitchHighRst     = 8'd10;
  localparam byte_t VibratoStepRst   = 8'd128;
  localparam byte_t VolumeStartRst   = 8'd0;
  localparam byte_t SplitPointRst    = 8'd255;
  localparam byte_t DecayExponentRst = 8'd6;
  localparam byte_t WidthRateRst     = 8'd7;
  localparam byte_t LinearDecayRst   = 8'd1;

endpackage

// ===== sv/psg_if.sv =====
interface psg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface psg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample;
  logic       last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

interface psg_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/pulse_sweep_sound_generator.sv =====
// Pulse-sweep sound-effect voice. Each request on in_ch is one tick; a tick with
// restart set reloads the voice from the registers and starts the sound. While the
// sound runs every tick yields one sample on out_ch, in the cycle after the request,
// and the sample on which the magnitude high byte reaches 0x80 carries last. Ticks
// outside a sound are taken and yield nothing. One tick is taken every cycle unless
// out_ch stalls: the whole step is a single pass from the voice registers into the
// output register, and a new request is taken whenever that register is empty or
// being drained. Register writes on cfg_ch are always taken; pitch, start volume
// and linear decay apply at the next restart, the others on the next tick.
`include "pulse_sweep_sound_generator_defines.svh"

module pulse_sweep_sound_generator
  import psg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  psg_in_if.sink    in_ch,
  psg_out_if.source out_ch,
  psg_cfg_if.sink   cfg_ch
);

  byte_t pitch_high_q, vibrato_step_q, volume_start_q, split_point_q;
  byte_t decay_exponent_q, width_rate_q, linear_decay_q;

  word_t phase_q, phase_d, phase_step_q, phase_step_d;
  word_t magnitude_q, magnitude_d, width_ramp_q, width_ramp_d;
  byte_t linear_term_q, linear_term_d;
  logic  running_q, running_d;

  logic  out_valid_q, out_valid_d;
  byte_t out_sample_q, out_sample_d;
  logic  out_last_q, out_last_d;

  logic  in_acc, run, out_load, fin;
  word_t cur_phase, cur_step, cur_mag, cur_width;
  byte_t cur_lin, mag_hi, term, new_hi;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_high_q     <= PitchHighRst;
      vibrato_step_q   <= VibratoStepRst;
      volume_start_q   <= VolumeStartRst;
      split_point_q    <= SplitPointRst;
      decay_exponent_q <= DecayExponentRst;
      width_rate_q     <= WidthRateRst;
      linear_decay_q   <= LinearDecayRst;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_PITCH_HIGH:     pitch_high_q     <= cfg_ch.data;
        REG_VIBRATO_STEP:   vibrato_step_q   <= cfg_ch.data;
        REG_VOLUME_START:   volume_start_q   <= cfg_ch.data;
        REG_SPLIT_POINT:    split_point_q    <= cfg_ch.data;
        REG_DECAY_EXPONENT: decay_exponent_q <= cfg_ch.data;
        REG_WIDTH_RATE:     width_rate_q     <= cfg_ch.data;
        REG_LINEAR_DECAY:   linear_decay_q   <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = !out_valid_q || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign run         = in_ch.restart || running_q;
  assign out_load    = in_acc && run;

  always_comb begin
    if (in_ch.restart) begin
      cur_phase = PhaseInit;
      cur_step  = {pitch_high_q, 8'd0};
      cur_mag   = {volume_start_q, volume_start_q};
      cur_width = WidthInit;
      cur_lin   = linear_decay_q;
    end else begin
      cur_phase = phase_q;
      cur_step  = phase_step_q;
      cur_mag   = magnitude_q;
      cur_width = width_ramp_q;
      cur_lin   = linear_term_q;
    end

    if (cur_phase[15:8] < split_point_q) begin
      phase_step_d = cur_step - {8'd0, vibrato_step_q};
    end else begin
      phase_step_d = cur_step + {8'd0, vibrato_step_q};
    end

    mag_hi = cur_mag[15:8];
    if (decay_exponent_q < ExpShiftLimit) begin
      term = mag_hi >> decay_exponent_q[3:0];
    end else if (decay_exponent_q >= ExpHalfMin) begin
      term = mag_hi >> 1;
    end else begin
      term = '0;
    end
    term = term | cur_lin;

    linear_term_d = (cur_lin == '0) ? LinearFloor : cur_lin;
    magnitude_d   = cur_mag - {8'd0, term};
    new_hi        = magnitude_d[15:8];
    fin           = (new_hi == EndLevel);
    width_ramp_d  = cur_width + {8'd0, width_rate_q};
    phase_d       = cur_phase + phase_step_d;

    out_sample_d = (phase_d[15:8] >= width_ramp_d[15:8]) ? new_hi : ~new_hi;
    out_last_d   = fin;
    running_d    = !fin;
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (out_load) begin
        running_q <= running_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      phase_q       <= phase_d;
      phase_step_q  <= phase_step_d;
      magnitude_q   <= magnitude_d;
      width_ramp_q  <= width_ramp_d;
      linear_term_q <= linear_term_d;
      out_sample_q  <= out_sample_d;
      out_last_q    <= out_last_d;
    end
  end

  assign out_ch.valid  = out_valid_q;
  assign out_ch.sample = out_sample_q;
  assign out_ch.last   = out_last_q;

  `PSG_ASSERT_NOW(a_ready_when_empty, clk_i, rst_ni, !out_valid_q, in_ch.ready)
  `PSG_ASSERT_NEXT(a_idle_tick_stays_idle, clk_i, rst_ni,
                   in_acc && !in_ch.restart && !running_q, !running_q && !out_valid_q)
  `PSG_ASSERT_NEXT(a_final_stops_voice, clk_i, rst_ni, out_load && fin, !running_q)
  `PSG_ASSERT_NOW(a_last_pending_idle, clk_i, rst_ni, out_valid_q && out_last_q, !running_q)

endmodule

// ===== bench/pulse_sweep_sound_generator_tb.sv =====
`timescale 1ns / 1ps

module pulse_sweep_sound_generator_tb;
  import psg_pkg::*;

  localparam logic [IndexW-1:0] RegSpare = 3'd7;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomSamples = 1100;
  localparam int unsigned SqueezeCycles = 300;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    byte_t sample;
    logic  last;
  } tone_t;

  class tone_scoreboard;
    byte_t pitch_high;
    byte_t vibrato_step;
    byte_t volume_start;
    byte_t split_point;
    byte_t decay_exponent;
    byte_t width_rate;
    byte_t linear_decay;
    word_t phase;
    word_t phase_step;
    word_t magnitude;
    word_t width_ramp;
    byte_t linear_term;
    bit running;
    tone_t tones_due[$];
    int unsigned samples_made;
    int unsigned mismatches;

    function new();
      pitch_high     = PitchHighRst;
      vibrato_step   = VibratoStepRst;
      volume_start   = VolumeStartRst;
      split_point    = SplitPointRst;
      decay_exponent = DecayExponentRst;
      width_rate     = WidthRateRst;
      linear_decay   = LinearDecayRst;
      reload();
      running = 1'b0;
      samples_made = 0;
      mismatches = 0;
    endfunction

    function void reload();
      phase       = PhaseInit;
      phase_step  = {pitch_high, 8'h00};
      magnitude   = {volume_start, volume_start};
      width_ramp  = WidthInit;
      linear_term = linear_decay;
    endfunction

    function void write_reg(logic [IndexW-1:0] idx, byte_t d);
      case (idx)
        REG_PITCH_HIGH:     pitch_high = d;
        REG_VIBRATO_STEP:   vibrato_step = d;
        REG_VOLUME_START:   volume_start = d;
        REG_SPLIT_POINT:    split_point = d;
        REG_DECAY_EXPONENT: decay_exponent = d;
        REG_WIDTH_RATE:     width_rate = d;
        REG_LINEAR_DECAY:   linear_decay = d;
        default: ;
      endcase
    endfunction

    function byte_t decay_of(byte_t hi);
      byte_t t;
      if (decay_exponent < ExpShiftLimit) begin
        t = hi >> decay_exponent;
      end else if (decay_exponent >= ExpHalfMin) begin
        t = hi >> 1;
      end else begin
        t = 8'h00;
      end
      return t;
    endfunction

    function void note_tick(logic restart);
      byte_t t;
      byte_t hi;
      tone_t e;
      if (restart) begin
        reload();
        running = 1'b1;
      end
      if (!running) return;
      if (phase[15:8] < split_point) begin
        phase_step = phase_step - {8'h00, vibrato_step};
      end else begin
        phase_step = phase_step + {8'h00, vibrato_step};
      end
      t = decay_of(magnitude[15:8]) | linear_term;
      if (linear_term == 8'h00) linear_term = LinearFloor;
      magnitude = magnitude - {8'h00, t};
      hi = magnitude[15:8];
      width_ramp = width_ramp + {8'h00, width_rate};
      phase = phase + phase_step;
      e.sample = (phase[15:8] >= width_ramp[15:8]) ? hi : ~hi;
      e.last = (hi == EndLevel);
      tones_due.push_back(e);
      samples_made++;
      if (e.last) running = 1'b0;
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      mismatches++;
    endtask

    task check_sample(byte_t sample, logic last);
      tone_t e;
      if (tones_due.size() == 0) begin
        report_mismatch("unexpected sample", sample, 0);
      end else begin
        e = tones_due.pop_front();
        if (sample !== e.sample) report_mismatch("sample", sample, e.sample);
        if (last !== e.last) report_mismatch("last", last, e.last);
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  idle_mode_e idle_mode;
  bit squeeze;
  bit squeezed;
  int unsigned cycles;
  tone_scoreboard sb;

  psg_in_if  in_ch ();
  psg_out_if out_ch ();
  psg_cfg_if cfg_ch ();

  pulse_sweep_sound_generator u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned sender_pct();
    case (idle_mode)
      IDLE_SENDER: return 46;
      IDLE_BOTH:   return 27;
      default:     return 0;
    endcase
  endfunction

  function automatic int unsigned receiver_pct();
    case (idle_mode)
      IDLE_RECEIVER: return 46;
      IDLE_BOTH:     return 27;
      default:       return 0;
    endcase
  endfunction

  // Receiver: random stalls, plus one long hold-off to back the block up.
  initial begin
    int unsigned held;
    held = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (squeeze && !squeezed) begin
        out_ch.ready = 1'b0;
        held++;
        if (held == SqueezeCycles) squeezed = 1'b1;
      end else begin
        out_ch.ready = ($urandom_range(99) >= receiver_pct());
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) sb.check_sample(out_ch.sample, out_ch.last);
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("pulse_sweep_sound_generator_tb failed");
        $finish;
      end
    end
  end

  task automatic tick(input logic restart);
    while ($urandom_range(99) < sender_pct()) begin
      in_ch.valid = 1'b0;
      in_ch.restart = 1'($urandom_range(1));
      @(negedge clk_i);
    end
    in_ch.valid = 1'b1;
    in_ch.restart = restart;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_tick(restart);
    @(negedge clk_i);
  endtask

  task automatic set_reg(input logic [IndexW-1:0] idx, input byte_t d);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = d;
    do @(posedge clk_i); while (!cfg_ch.ready);
    sb.write_reg(idx, d);
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (sb.tones_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic tune(input byte_t pitch, input byte_t vib, input byte_t vol, input byte_t split,
                      input byte_t expo, input byte_t rate, input byte_t lin);
    set_reg(REG_PITCH_HIGH, pitch);
    set_reg(REG_VIBRATO_STEP, vib);
    set_reg(REG_VOLUME_START, vol);
    set_reg(REG_SPLIT_POINT, split);
    set_reg(REG_DECAY_EXPONENT, expo);
    set_reg(REG_WIDTH_RATE, rate);
    set_reg(REG_LINEAR_DECAY, lin);
  endtask

  function automatic byte_t pick_byte();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return byte_t'($urandom_range(255));
    endcase
  endfunction

  // Favour short exponents so that sounds reach their end often.
  function automatic byte_t pick_exponent();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return 8'd0;
    if (r < 55) return byte_t'($urandom_range(2, 1));
    if (r < 65) return byte_t'($urandom_range(127, 9));
    if (r < 75) return byte_t'($urandom_range(255, 128));
    return byte_t'($urandom_range(255));
  endfunction

  initial begin
    byte_t exps [4];
    int unsigned phase_no;
    int unsigned start_count;
    int unsigned target;
    int unsigned sent;

    sb = new();
    rst_ni = 1'b0;
    idle_mode = IDLE_NONE;
    squeeze = 1'b0;
    squeezed = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.restart = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Idle ticks, then a sound from the reset settings with a wrapping magnitude.
    tick(1'b0);
    tick(1'b0);
    tick(1'b1);
    tick(1'b0);
    tick(1'b0);
    tick(1'b0);
    drain();

    tune(8'hff, 8'hff, 8'hff, 8'h00, 8'hff, 8'hff, 8'hff);
    set_reg(RegSpare, 8'h55);
    tick(1'b1);
    tick(1'b0);
    tick(1'b0);
    tick(1'b0);
    drain();

    // Zero linear term and a sound that ends on its second sample.
    tune(8'h00, 8'h00, 8'h81, 8'hff, 8'h00, 8'h00, 8'h00);
    tick(1'b1);
    tick(1'b0);
    tick(1'b0);
    tick(1'b0);
    drain();

    exps = '{8'd8, 8'd9, 8'd127, 8'd128};
    foreach (exps[i]) begin
      set_reg(REG_DECAY_EXPONENT, exps[i]);
      tick(1'b1);
      tick(1'b0);
      drain();
    end

    phase_no = 0;
    start_count = sb.samples_made;
    while (sb.samples_made - start_count < RandomSamples) begin
      idle_mode = idle_mode_e'(phase_no % 4);
      tune(pick_byte(), pick_byte(), byte_t'($urandom_range(255)), pick_byte(),
           pick_exponent(), pick_byte(), pick_byte());
      if ($urandom_range(4) == 0) set_reg(RegSpare, byte_t'($urandom_range(255)));
      if (phase_no == 2) squeeze = 1'b1;
      target = sb.samples_made + $urandom_range(160, 80);
      sent = 0;
      tick(1'b1);
      while (sb.samples_made < target && sent < 600) begin
        if (!sb.running) begin
          tick($urandom_range(99) < 60);
        end else begin
          tick($urandom_range(99) < 3);
        end
        sent++;
      end
      drain();
      phase_no++;
    end

    repeat (8) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.tones_due.size() == 0) begin
      $display("pulse_sweep_sound_generator_tb passed");
    end else begin
      $display("pulse_sweep_sound_generator_tb failed");
    end
    $finish;
  end

endmodule
